FILE: sv/speed_to_hbridge_pwm_unit_defines.svh
// Assertion macros shared by the speed to H-bridge PWM unit.
`ifndef SPEED_TO_HBRIDGE_PWM_UNIT_DEFINES_SVH
`define SPEED_TO_HBRIDGE_PWM_UNIT_DEFINES_SVH

// Plain clocked property, disabled while reset is asserted.
`define SPWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication built on the plain form.
`define SPWM_ASSERT_IMPL(lbl, ante, cons, msg) \
	`SPWM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: sv/spwm_pkg.sv
// Types and constants of the speed to H-bridge PWM unit.
`default_nettype none
package spwm_pkg;

	localparam int NUM_MOTORS = 4;
	localparam int MOTOR_BITS = 2;
	localparam int CMD_BITS   = 16;
	localparam int DB_BITS    = 15;
	localparam int INV_BITS   = 31;
	localparam int DUTY_BITS  = 12;
	localparam int MASK_BITS  = 4;
	localparam int N_BITS     = 16;
	localparam int PROD_BITS  = CMD_BITS + INV_BITS;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam int Q15_ONE  = 32768;
	localparam int DUTY_MAX = 4095;

	localparam logic [DB_BITS-1:0]   DEADBAND_RST  = '0;
	localparam logic [INV_BITS-1:0]  INV_MAX_RST   = 31'd838861;
	localparam logic [DUTY_BITS-1:0] MIN_DUTY_RST  = '0;
	localparam logic [DUTY_BITS-1:0] MAX_DUTY_RST  = 12'd4095;
	localparam logic [MASK_BITS-1:0] DIR_MASK_RST  = '0;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DEADBAND = 3'd0,
		REG_INV_MAX  = 3'd1,
		REG_MIN_DUTY = 3'd2,
		REG_MAX_DUTY = 3'd3,
		REG_DIR_MASK = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [DB_BITS-1:0]   deadband;
		logic [INV_BITS-1:0]  inverse_max_speed;
		logic [DUTY_BITS-1:0] min_duty;
		logic [DUTY_BITS-1:0] max_duty;
		logic [MASK_BITS-1:0] direction_mask;
	} cfg_t;

	typedef struct packed {
		logic [MOTOR_BITS-1:0]      motor_index;
		logic signed [CMD_BITS-1:0] velocity_command;
	} in_word_t;

	typedef struct packed {
		logic [MOTOR_BITS-1:0] motor_id;
		logic [DUTY_BITS-1:0]  forward_duty;
		logic [DUTY_BITS-1:0]  reverse_duty;
		logic                  reverse_active;
	} out_word_t;

	// Normalised magnitude handed from the scaling stages to the duty stages.
	typedef struct packed {
		logic [MOTOR_BITS-1:0] motor;
		logic                  rev;
		logic [N_BITS-1:0]     n;
	} norm_word_t;

endpackage
`default_nettype wire

FILE: sv/spwm_cfg.sv
// Configuration register file of the speed to H-bridge PWM unit.
`default_nettype none
module spwm_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [spwm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [spwm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output spwm_pkg::cfg_t                           cfg
);
	import spwm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband          <= DEADBAND_RST;
			cfg_q.inverse_max_speed <= INV_MAX_RST;
			cfg_q.min_duty          <= MIN_DUTY_RST;
			cfg_q.max_duty          <= MAX_DUTY_RST;
			cfg_q.direction_mask    <= DIR_MASK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEADBAND: cfg_q.deadband          <= cfg_data[DB_BITS-1:0];
				REG_INV_MAX:  cfg_q.inverse_max_speed <= cfg_data[INV_BITS-1:0];
				REG_MIN_DUTY: cfg_q.min_duty          <= cfg_data[DUTY_BITS-1:0];
				REG_MAX_DUTY: cfg_q.max_duty          <= cfg_data[DUTY_BITS-1:0];
				REG_DIR_MASK: cfg_q.direction_mask    <= cfg_data[MASK_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/spwm_norm.sv
// Deadband, direction and Q1.15 normalisation stages (s1 to s3).
`default_nettype none
module spwm_norm (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire spwm_pkg::cfg_t       cfg,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire spwm_pkg::in_word_t   in_data,
	output logic                      dn_valid,
	input  wire logic                 dn_ready,
	output spwm_pkg::norm_word_t      dn_data
);
	import spwm_pkg::*;

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  en_s1, en_s2, en_s3;
	logic [MOTOR_BITS-1:0] motor_s1, motor_s2, motor_s3;
	logic                  rev_s1, rev_s2, rev_s3;
	logic [CMD_BITS-1:0]   mag_s1;
	logic [PROD_BITS-1:0]  prod_s2;
	logic [N_BITS-1:0]     n_s3;

	logic [CMD_BITS-1:0]   raw;
	logic                  neg;
	logic [CMD_BITS-1:0]   mag;
	logic                  dead;
	logic                  invert;
	logic [PROD_BITS-1:0]  rnd;
	logic [PROD_BITS-17:0] scaled;

	assign en_s3    = !valid_s3 || dn_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// The most negative command has no positive twin; its two's complement is
	// 0x8000, which reads correctly as an unsigned magnitude.
	always_comb begin
		raw    = in_data.velocity_command;
		neg    = raw[CMD_BITS-1];
		mag    = neg ? (~raw + 1'b1) : raw;
		dead   = mag <= {1'b0, cfg.deadband};
		invert = ({1'b0, in_data.motor_index} < (MOTOR_BITS+1)'(NUM_MOTORS))
			&& cfg.direction_mask[in_data.motor_index];
	end

	always_comb begin
		rnd    = prod_s2 + PROD_BITS'(Q15_ONE);
		scaled = rnd[PROD_BITS-1:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			motor_s1 <= in_data.motor_index;
			mag_s1   <= dead ? '0 : mag;
			rev_s1   <= !dead && (neg ^ invert);
		end
		if (en_s2 && valid_s1) begin
			motor_s2 <= motor_s1;
			rev_s2   <= rev_s1;
			prod_s2  <= PROD_BITS'(mag_s1) * PROD_BITS'(cfg.inverse_max_speed);
		end
		if (en_s3 && valid_s2) begin
			motor_s3 <= motor_s2;
			rev_s3   <= rev_s2;
			n_s3     <= (scaled > (PROD_BITS-16)'(Q15_ONE)) ? N_BITS'(Q15_ONE)
				: scaled[N_BITS-1:0];
		end
	end

	assign dn_valid      = valid_s3;
	assign dn_data.motor = motor_s3;
	assign dn_data.rev   = rev_s3;
	assign dn_data.n     = n_s3;

endmodule
`default_nettype wire

FILE: sv/spwm_duty.sv
// Linear duty mapping and output register (s4 and s5).
`default_nettype none
module spwm_duty (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire spwm_pkg::cfg_t       cfg,
	input  wire logic                 up_valid,
	output logic                      up_ready,
	input  wire spwm_pkg::norm_word_t up_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output spwm_pkg::out_word_t       out_data
);
	import spwm_pkg::*;

	localparam int SPAN_BITS = DUTY_BITS + 1;
	localparam int MUL_BITS  = N_BITS + 1 + SPAN_BITS;
	localparam int ACC_BITS  = 32;

	logic                        valid_s4, valid_s5;
	logic                        en_s4, en_s5;
	logic [MOTOR_BITS-1:0]       motor_s4;
	logic                        rev_s4;
	logic                        nz_s4;
	logic signed [MUL_BITS-1:0]  prod_s4;
	out_word_t                   word_s5;

	logic signed [SPAN_BITS-1:0] span;
	logic signed [N_BITS:0]      n_sg;
	logic signed [ACC_BITS-1:0]  acc;
	logic [ACC_BITS-16:0]        q;
	logic [DUTY_BITS-1:0]        duty;

	assign en_s5    = !valid_s5 || out_ready;
	assign en_s4    = !valid_s4 || en_s5;
	assign up_ready = en_s4;

	always_comb begin
		span = $signed({1'b0, cfg.max_duty}) - $signed({1'b0, cfg.min_duty});
		n_sg = $signed({1'b0, up_data.n});
	end

	// min_duty * 2^15 plus the scaled span plus half an LSB, then shift down.
	always_comb begin
		acc = $signed({(ACC_BITS-DUTY_BITS-15)'(0), cfg.min_duty, 15'd0})
			+ ACC_BITS'(prod_s4) + ACC_BITS'(16384);
		q   = acc[ACC_BITS-1:15];
		if (!nz_s4 || acc[ACC_BITS-1]) begin
			duty = '0;
		end else if (q > (ACC_BITS-15)'(DUTY_MAX)) begin
			duty = DUTY_BITS'(DUTY_MAX);
		end else begin
			duty = q[DUTY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s4) valid_s4 <= up_valid;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && up_valid) begin
			motor_s4 <= up_data.motor;
			rev_s4   <= up_data.rev;
			nz_s4    <= up_data.n != '0;
			prod_s4  <= MUL_BITS'(n_sg) * MUL_BITS'(span);
		end
		if (en_s5 && valid_s4) begin
			word_s5.motor_id       <= motor_s4;
			word_s5.forward_duty   <= rev_s4 ? '0 : duty;
			word_s5.reverse_duty   <= rev_s4 ? duty : '0;
			word_s5.reverse_active <= rev_s4;
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = word_s5;

endmodule
`default_nettype wire

FILE: sv/speed_to_hbridge_pwm_unit.sv
// An accepted command word passes through the registered stages s1 to s5 before its duty word reaches the output.
// Throughput: one word per cycle while out_ready is high; the two multipliers (16x31 and 17x13) each own a stage.
// Each stage moves on when it is empty or its successor moves, so bubbles close up.
// Reset (arst_n low, asynchronous) empties all stages and loads the register defaults.
// Configuration writes are taken every cycle; words in flight would see new values mid-way.
`default_nettype none
module speed_to_hbridge_pwm_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [spwm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [spwm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire spwm_pkg::in_word_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output spwm_pkg::out_word_t                      out_data
);
	import spwm_pkg::*;
	`include "speed_to_hbridge_pwm_unit_defines.svh"

	cfg_t       cfg;
	logic       mid_valid;
	logic       mid_ready;
	norm_word_t mid_data;

	spwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spwm_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.dn_valid (mid_valid),
		.dn_ready (mid_ready),
		.dn_data  (mid_data)
	);

	spwm_duty u_duty (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.up_valid  (mid_valid),
		.up_ready  (mid_ready),
		.up_data   (mid_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Only one half-bridge may ever carry a nonzero duty.
	`SPWM_ASSERT_IMPL(a_one_side, out_valid,
		(out_data.forward_duty == '0) || (out_data.reverse_duty == '0),
		"both half-bridge channels driven")
	`SPWM_ASSERT_IMPL(a_fwd_side, out_valid && !out_data.reverse_active,
		out_data.reverse_duty == '0, "reverse duty set on a forward word")
	`SPWM_ASSERT_IMPL(a_rev_side, out_valid && out_data.reverse_active,
		out_data.forward_duty == '0, "forward duty set on a reverse word")
	`SPWM_ASSERT_IMPL(a_norm_sat, mid_valid,
		mid_data.n <= N_BITS'(Q15_ONE), "normalised magnitude above 1.0")

endmodule
`default_nettype wire
